// File: src/bmps_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and helpers for the BMP pixel stream decoder.
// Used by bmps_core and bmp_pixel_stream_to_screen_top; no dependencies.
package bmps_pkg;

    localparam int MAX_DIM    = 4096;  // largest image side, larger sizes saturate
    localparam int DIM_W      = 13;    // holds 0..MAX_DIM
    localparam int COORD_W    = 13;
    localparam int ORG_W      = 12;
    localparam int SIZE_W     = 14;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 14;
    localparam int COLOR_W    = 32;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ORIGIN_ROW    = 3'd0,
        REG_ORIGIN_COL    = 3'd1,
        REG_IMAGE_WIDTH   = 3'd2,
        REG_IMAGE_HEIGHT  = 3'd3,
        REG_ALPHA_PRESENT = 3'd4
    } cfg_index_t;

    typedef enum logic [1:0] {
        PH_BLUE  = 2'd0,
        PH_GREEN = 2'd1,
        PH_RED   = 2'd2,
        PH_ALPHA = 2'd3
    } phase_t;

    typedef struct packed {
        logic [ORG_W-1:0]         origin_row;
        logic [ORG_W-1:0]         origin_col;
        logic signed [SIZE_W-1:0] image_width;
        logic signed [SIZE_W-1:0] image_height;
        logic                     alpha_present;
    } cfg_t;

    typedef struct packed {
        logic [COORD_W-1:0] pixel_row;
        logic [COORD_W-1:0] pixel_col;
        logic [COLOR_W-1:0] color;
        logic               last_pixel;
    } pixel_t;

    // Magnitude of a signed image side, saturated to MAX_DIM.
    function automatic logic [DIM_W-1:0] dim_mag(input logic [SIZE_W-1:0] raw);
        logic [SIZE_W-1:0] mag;
        mag = raw[SIZE_W-1] ? (SIZE_W'(0) - raw) : raw;
        if (mag > SIZE_W'(MAX_DIM))
            return DIM_W'(MAX_DIM);
        return mag[DIM_W-1:0];
    endfunction

endpackage

// File: src/bmps_core.sv
`timescale 1ns / 1ps
// Byte gathering, padding skip and screen coordinate mapping.
// Depends on bmps_pkg; output registering is done in the top level.
module bmps_core (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  fire,
    input  logic [7:0]            data_byte,
    input  bmps_pkg::cfg_t        cfg,
    output logic                  res_valid,
    output bmps_pkg::pixel_t      res
);
    import bmps_pkg::*;

    phase_t             phase_reg, phase_next;
    logic [DIM_W-1:0]   col_reg, col_next;
    logic [DIM_W-1:0]   row_reg, row_next;
    logic [1:0]         pad_reg, pad_next;
    logic [7:0]         blue_reg, blue_next;
    logic [7:0]         green_reg, green_next;
    logic [7:0]         red_reg, red_next;

    logic [DIM_W-1:0]   w, h;
    logic [DIM_W-1:0]   row_off, col_off;
    logic               last_col, last_row;
    logic               pix_done;
    logic [7:0]         red, alpha;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_BLUE;
            col_reg   <= '0;
            row_reg   <= '0;
            pad_reg   <= '0;
            blue_reg  <= '0;
            green_reg <= '0;
            red_reg   <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            col_reg   <= col_next;
            row_reg   <= row_next;
            pad_reg   <= pad_next;
            blue_reg  <= blue_next;
            green_reg <= green_next;
            red_reg   <= red_next;
        end
    end

    always_comb
    begin
        w = dim_mag(cfg.image_width);
        h = dim_mag(cfg.image_height);

        // bottom-up storage when height is positive; mirror when width is negative
        row_off = !cfg.image_height[SIZE_W-1] ? (h - DIM_W'(1) - row_reg) : row_reg;
        col_off = cfg.image_width[SIZE_W-1] ? (w - DIM_W'(1) - col_reg) : col_reg;
        last_col = col_reg >= (w - DIM_W'(1));
        last_row = row_reg >= (h - DIM_W'(1));

        phase_next = phase_reg;
        col_next   = col_reg;
        row_next   = row_reg;
        pad_next   = pad_reg;
        blue_next  = blue_reg;
        green_next = green_reg;
        red_next   = red_reg;
        pix_done   = 1'b0;
        red        = data_byte;
        alpha      = 8'd0;

        if (fire && w != '0 && h != '0)
        begin
            if (pad_reg != 2'd0)
            begin
                pad_next = pad_reg - 2'd1;
            end
            else
            begin
                unique case (phase_reg)
                    PH_BLUE:
                    begin
                        blue_next  = data_byte;
                        phase_next = PH_GREEN;
                    end
                    PH_GREEN:
                    begin
                        green_next = data_byte;
                        phase_next = PH_RED;
                    end
                    PH_RED:
                    begin
                        red_next = data_byte;
                        if (cfg.alpha_present)
                            phase_next = PH_ALPHA;
                        else
                            pix_done = 1'b1;
                    end
                    PH_ALPHA:
                    begin
                        // alpha turned off mid-pixel: this byte is red
                        if (cfg.alpha_present)
                        begin
                            red   = red_reg;
                            alpha = data_byte;
                        end
                        else
                        begin
                            red_next = data_byte;
                        end
                        pix_done = 1'b1;
                    end
                endcase

                if (pix_done)
                begin
                    phase_next = PH_BLUE;
                    if (last_col)
                    begin
                        col_next = '0;
                        row_next = last_row ? '0 : row_reg + DIM_W'(1);
                        // row padding of 3*w bytes to a multiple of 4 is w mod 4
                        pad_next = cfg.alpha_present ? 2'd0 : w[1:0];
                    end
                    else
                    begin
                        col_next = col_reg + DIM_W'(1);
                    end
                end
            end
        end

        res_valid      = pix_done;
        res.pixel_row  = COORD_W'({1'b0, cfg.origin_row}) + row_off;
        res.pixel_col  = COORD_W'({1'b0, cfg.origin_col}) + col_off;
        res.color      = {alpha, red, green_reg, blue_reg};
        res.last_pixel = last_col && last_row;
    end

    a_pad_phase: assert property (@(posedge clk) disable iff (!rst_n)
        (pad_reg != 2'd0) |-> (phase_reg == PH_BLUE))
        else $error("padding skip while a pixel is half gathered");

    a_row_end: assert property (@(posedge clk) disable iff (!rst_n)
        (pix_done && last_col) |=> (col_reg == '0))
        else $error("column count not cleared at row end");

    a_image_end: assert property (@(posedge clk) disable iff (!rst_n)
        (pix_done && res.last_pixel) |=> (col_reg == '0 && row_reg == '0))
        else $error("counters not rewound after final pixel");

    a_idle_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !fire |=> $stable(phase_reg) && $stable(pad_reg) && $stable(col_reg))
        else $error("state moved without a byte transfer");

endmodule

// File: src/bmp_pixel_stream_to_screen_top.sv
`timescale 1ns / 1ps
// BMP pixel array byte stream to screen pixels: config registers and output stage.
// A pixel is registered and presented in the cycle after the transfer of its last byte.
// Throughput: one byte per cycle; a byte transfers whenever the output register is
// empty or being drained, and every byte stalls while a held pixel is stalled.
// Reset (rst_n, async low): all but the output data register reset, no pixel pending.
module bmp_pixel_stream_to_screen_top (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [bmps_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [bmps_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [7:0]                          data_byte,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [bmps_pkg::COORD_W-1:0]        pixel_row,
    output logic [bmps_pkg::COORD_W-1:0]        pixel_col,
    output logic [bmps_pkg::COLOR_W-1:0]        color,
    output logic                                last_pixel
);
    import bmps_pkg::*;

    cfg_t   cfg_reg, cfg_next;
    pixel_t out_reg, out_next;
    logic   out_valid_reg, out_valid_next;
    logic   fire;
    logic   res_valid;
    pixel_t res;

    assign in_stall = out_valid_reg && out_stall;
    assign fire     = in_valid && !in_stall;

    bmps_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .fire      (fire),
        .data_byte (data_byte),
        .cfg       (cfg_reg),
        .res_valid (res_valid),
        .res       (res)
    );

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index_t'(cfg_index))
                REG_ORIGIN_ROW:    cfg_next.origin_row    = cfg_data[ORG_W-1:0];
                REG_ORIGIN_COL:    cfg_next.origin_col    = cfg_data[ORG_W-1:0];
                REG_IMAGE_WIDTH:   cfg_next.image_width   = cfg_data[SIZE_W-1:0];
                REG_IMAGE_HEIGHT:  cfg_next.image_height  = cfg_data[SIZE_W-1:0];
                REG_ALPHA_PRESENT: cfg_next.alpha_present = cfg_data[0];
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        out_next       = out_reg;
        out_valid_next = out_valid_reg;
        if (fire && res_valid)
        begin
            out_next       = res;
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.origin_row    <= '0;
            cfg_reg.origin_col    <= '0;
            cfg_reg.image_width   <= SIZE_W'(1);
            cfg_reg.image_height  <= SIZE_W'(1);
            cfg_reg.alpha_present <= 1'b0;
            out_valid_reg         <= 1'b0;
        end
        else
        begin
            cfg_reg       <= cfg_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    assign out_valid  = out_valid_reg;
    assign pixel_row  = out_reg.pixel_row;
    assign pixel_col  = out_reg.pixel_col;
    assign color      = out_reg.color;
    assign last_pixel = out_reg.last_pixel;

    a_no_drop: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && res_valid) |=> out_valid_reg)
        else $error("pixel lost on the way to the output register");

    a_no_ghost: assert property (@(posedge clk) disable iff (!rst_n)
        (!(fire && res_valid) && !out_stall) |=> !out_valid_reg)
        else $error("output valid without a new pixel");

endmodule

// File: tb/testbench.sv
`timescale 1ns / 1ps
// Self-checking bench for bmp_pixel_stream_to_screen_top: byte stream in, screen pixels out.
// Needs bmps_pkg and the RTL top; a local predictor works out each pixel, checked field by field.
module testbench;
    import bmps_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 400000;
    localparam int unsigned MAX_PRINTS = 100;
    localparam int unsigned RANDOM_ITEMS = 1250;
    localparam int unsigned PHASE_BYTES = 80;
    localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = 3'd7;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic                  in_valid = 1'b0;
    logic                  in_stall;
    logic [7:0]            data_byte = '0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    logic [COORD_W-1:0]    pixel_row;
    logic [COORD_W-1:0]    pixel_col;
    logic [COLOR_W-1:0]    color;
    logic                  last_pixel;

    // predictor copy of the registers and decode state
    logic [ORG_W-1:0]      org_row_reg;
    logic [ORG_W-1:0]      org_col_reg;
    logic [SIZE_W-1:0]     width_reg;
    logic [SIZE_W-1:0]     height_reg;
    logic                  alpha_reg;
    phase_t                next_byte;
    logic [COORD_W-1:0]    col_pos;
    logic [COORD_W-1:0]    row_pos;
    logic [1:0]            pad_left;
    logic [7:0]            blue_byte;
    logic [7:0]            green_byte;
    logic [7:0]            red_byte;

    pixel_t                pixel_expect[$];
    pixel_t                pixel_want;
    logic [7:0]            byte_queue[$];
    int unsigned           idle_pct = 0;
    int unsigned           stall_pct = 0;
    int unsigned           mismatches = 0;
    int unsigned           cycle_count = 0;

    bmp_pixel_stream_to_screen_top uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .data_byte  (data_byte),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .pixel_row  (pixel_row),
        .pixel_col  (pixel_col),
        .color      (color),
        .last_pixel (last_pixel)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    // side length from the signed header value, clipped at MAX_DIM
    function automatic logic [DIM_W-1:0] side_size(input logic [SIZE_W-1:0] raw);
        int m;
        m = raw[SIZE_W-1] ? (1 << SIZE_W) - int'(raw) : int'(raw);
        if (m > MAX_DIM)
            m = MAX_DIM;
        return DIM_W'(m);
    endfunction

    task automatic decoder_reset();
        org_row_reg = '0;
        org_col_reg = '0;
        width_reg = SIZE_W'(1);
        height_reg = SIZE_W'(1);
        alpha_reg = 1'b0;
        next_byte = PH_BLUE;
        col_pos = '0;
        row_pos = '0;
        pad_left = '0;
        blue_byte = '0;
        green_byte = '0;
        red_byte = '0;
    endtask

    function automatic void decode_byte(input logic [7:0] b);
        logic [DIM_W-1:0]   w;
        logic [DIM_W-1:0]   h;
        logic [7:0]         red;
        logic [7:0]         alpha;
        logic [COORD_W-1:0] row_off;
        logic [COORD_W-1:0] col_off;
        logic               end_col;
        logic               end_row;
        pixel_t             px;
        w = side_size(width_reg);
        h = side_size(height_reg);
        red = b;
        alpha = '0;
        if (w == 0 || h == 0)
            return;
        if (pad_left != 0)
        begin
            pad_left = pad_left - 2'd1;
            return;
        end
        case (next_byte)
            PH_BLUE:
            begin
                blue_byte = b;
                next_byte = PH_GREEN;
                return;
            end
            PH_GREEN:
            begin
                green_byte = b;
                next_byte = PH_RED;
                return;
            end
            PH_RED:
            begin
                red_byte = b;
                if (alpha_reg)
                begin
                    next_byte = PH_ALPHA;
                    return;
                end
            end
            default:
            begin
                // alpha cleared while waiting for the alpha byte: it becomes red
                if (alpha_reg)
                begin
                    red = red_byte;
                    alpha = b;
                end
                else
                    red_byte = b;
            end
        endcase
        next_byte = PH_BLUE;

        // positive height: stored bottom-up, so flip rows
        if (!height_reg[SIZE_W-1] && height_reg != 0)
            row_off = COORD_W'(int'(h) - 1 - int'(row_pos));
        else
            row_off = row_pos;
        if (width_reg[SIZE_W-1])
            col_off = COORD_W'(int'(w) - 1 - int'(col_pos));
        else
            col_off = col_pos;
        end_col = int'(col_pos) >= int'(w) - 1;
        end_row = int'(row_pos) >= int'(h) - 1;

        px.pixel_row = COORD_W'(int'(org_row_reg) + int'(row_off));
        px.pixel_col = COORD_W'(int'(org_col_reg) + int'(col_off));
        px.color = {alpha, red, green_byte, blue_byte};
        px.last_pixel = end_col && end_row;
        pixel_expect.push_back(px);

        if (end_col)
        begin
            col_pos = '0;
            row_pos = end_row ? '0 : row_pos + COORD_W'(1);
            pad_left = alpha_reg ? 2'd0 : 2'((4 - ((int'(w) * 3) & 3)) & 3);
        end
        else
            col_pos = col_pos + COORD_W'(1);
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        mismatches++;
        if (mismatches <= MAX_PRINTS)
            $display("mismatch %s: got %0h, want %0h at %0t", what, got, want, $realtime);
    endtask

    // driver: a new byte is loaded only when the bus is free or the last one transferred
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            data_byte <= '0;
        end
        else
        begin
            if (in_valid && !in_stall)
                decode_byte(data_byte);
            if (!in_valid || !in_stall)
            begin
                if (byte_queue.size() > 0 && $urandom_range(99) >= idle_pct)
                begin
                    in_valid <= 1'b1;
                    data_byte <= byte_queue.pop_front();
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (pixel_expect.size() == 0)
                    report_mismatch("pixel with none expected",
                                    32'({pixel_row, pixel_col}), '0);
                else
                begin
                    pixel_want = pixel_expect.pop_front();
                    if (pixel_row !== pixel_want.pixel_row)
                        report_mismatch("pixel_row", 32'(pixel_row),
                                        32'(pixel_want.pixel_row));
                    if (pixel_col !== pixel_want.pixel_col)
                        report_mismatch("pixel_col", 32'(pixel_col),
                                        32'(pixel_want.pixel_col));
                    if (color !== pixel_want.color)
                        report_mismatch("color", color, pixel_want.color);
                    if (last_pixel !== pixel_want.last_pixel)
                        report_mismatch("last_pixel", 32'(last_pixel),
                                        32'(pixel_want.last_pixel));
                end
            end
            out_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            REG_ORIGIN_ROW:    org_row_reg = value[ORG_W-1:0];
            REG_ORIGIN_COL:    org_col_reg = value[ORG_W-1:0];
            REG_IMAGE_WIDTH:   width_reg = value;
            REG_IMAGE_HEIGHT:  height_reg = value;
            REG_ALPHA_PRESENT: alpha_reg = value[0];
            default:           ;
        endcase
    endtask

    // sender holds off until every pixel is back and the pipe has emptied;
    // checked on the falling edge so the driver's updates have settled
    task automatic wait_idle();
        while (!(byte_queue.size() == 0 && !in_valid && pixel_expect.size() == 0))
            @(negedge clk);
        repeat (4) @(posedge clk);
    endtask

    function automatic logic [CFG_DATA_W-1:0] pick_origin();
        case ($urandom_range(3))
            0:       return '0;
            1:       return CFG_DATA_W'(12'hFFF);
            default: return CFG_DATA_W'($urandom);
        endcase
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pick_side();
        logic [CFG_DATA_W-1:0] mag;
        case ($urandom_range(15))
            0:       return '0;
            1:       return CFG_DATA_W'(MAX_DIM);
            2:       return CFG_DATA_W'(-MAX_DIM);
            3:       return CFG_DATA_W'($urandom);
            default:
            begin
                mag = CFG_DATA_W'($urandom_range(1, 6));
                return $urandom_range(1) ? -mag : mag;
            end
        endcase
    endfunction

    // whole images with random pixels; now and then one is cut short, a large one always
    task automatic fill_images(output int unsigned counted);
        int unsigned w;
        int unsigned h;
        int unsigned row_bytes;
        int unsigned img_bytes;
        int unsigned total;
        w = int'(side_size(width_reg));
        h = int'(side_size(height_reg));
        counted = 0;
        if (w == 0 || h == 0)
        begin
            repeat (12) byte_queue.push_back(8'($urandom));
            return;
        end
        row_bytes = alpha_reg ? w * 4 : w * 3 + ((4 - (w * 3) % 4) % 4);
        img_bytes = row_bytes * h;
        if (img_bytes > 4 * PHASE_BYTES)
            total = PHASE_BYTES;
        else
        begin
            total = img_bytes * ((PHASE_BYTES + img_bytes - 1) / img_bytes);
            if ($urandom_range(4) == 0)
                total = total - $urandom_range(1, img_bytes - 1);
        end
        repeat (total) byte_queue.push_back(8'($urandom));
        counted = total;
    endtask

    initial
    begin
        int unsigned random_items;
        int unsigned phase_no;
        int unsigned got;
        decoder_reset();
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // reset geometry, 1x1 24-bit: one pixel then one pad byte
        byte_queue.push_back(8'h00);
        byte_queue.push_back(8'hFF);
        byte_queue.push_back(8'h80);
        byte_queue.push_back(8'h7F);
        wait_idle();

        // far origin, mirrored, top-down, 32-bit
        write_reg(REG_ORIGIN_ROW, CFG_DATA_W'(12'hFFF));
        write_reg(REG_ORIGIN_COL, 14'h3FFF);
        write_reg(REG_IMAGE_WIDTH, 14'h3FFE);
        write_reg(REG_IMAGE_HEIGHT, 14'h3FFF);
        write_reg(REG_ALPHA_PRESENT, 14'h0001);
        write_reg(REG_UNMAPPED, 14'h3FFF);
        repeat (4) byte_queue.push_back(8'hFF);
        byte_queue.push_back(8'h01);
        byte_queue.push_back(8'h02);
        byte_queue.push_back(8'h03);
        byte_queue.push_back(8'h04);
        wait_idle();

        // alpha dropped while the alpha byte is due
        byte_queue.push_back(8'h10);
        byte_queue.push_back(8'h20);
        byte_queue.push_back(8'h30);
        wait_idle();
        write_reg(REG_ALPHA_PRESENT, 14'h0000);
        byte_queue.push_back(8'h40);
        wait_idle();

        // zero width: bytes ignored
        write_reg(REG_IMAGE_WIDTH, 14'h0000);
        byte_queue.push_back(8'h00);
        byte_queue.push_back(8'hFF);
        wait_idle();

        // oversized sides clip at MAX_DIM
        write_reg(REG_IMAGE_WIDTH, 14'h1FFF);
        write_reg(REG_IMAGE_HEIGHT, 14'h2000);
        byte_queue.push_back(8'h55);
        byte_queue.push_back(8'hAA);
        byte_queue.push_back(8'h0F);
        byte_queue.push_back(8'hF0);
        byte_queue.push_back(8'h81);
        byte_queue.push_back(8'h7E);
        wait_idle();

        // shrink under a running column count: mirrored column wraps
        write_reg(REG_IMAGE_WIDTH, 14'h3FFF);
        write_reg(REG_IMAGE_HEIGHT, 14'h3FFF);
        byte_queue.push_back(8'hA5);
        byte_queue.push_back(8'h5A);
        byte_queue.push_back(8'hC3);
        byte_queue.push_back(8'h3C);
        wait_idle();

        random_items = 0;
        phase_no = 0;
        while (random_items < RANDOM_ITEMS)
        begin
            case (phase_no % 4)
                0:
                begin
                    idle_pct = 0;
                    stall_pct = 0;
                end
                1:
                begin
                    idle_pct = 82;
                    stall_pct = 0;
                end
                2:
                begin
                    idle_pct = 0;
                    stall_pct = 82;
                end
                default:
                begin
                    idle_pct = 9;
                    stall_pct = 9;
                end
            endcase
            write_reg(REG_ORIGIN_ROW, pick_origin());
            write_reg(REG_ORIGIN_COL, pick_origin());
            write_reg(REG_IMAGE_WIDTH, pick_side());
            write_reg(REG_IMAGE_HEIGHT, pick_side());
            write_reg(REG_ALPHA_PRESENT, CFG_DATA_W'($urandom_range(1)));
            fill_images(got);
            random_items += got;
            wait_idle();
            phase_no++;
        end

        repeat (8) @(posedge clk);
        if (mismatches == 0 && pixel_expect.size() == 0)
            $display("bmp_pixel_stream_to_screen_top verification clean");
        else
            $display("bmp_pixel_stream_to_screen_top verification failed");
        $finish;
    end

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("bmp_pixel_stream_to_screen_top verification failed");
        $finish;
    end

endmodule
